/* src/bei_pkg.sv */
// Shared types and constants of the breakpoint envelope interpolator.
package bei_pkg;

  localparam int TIME_W   = 17;
  localparam int VALUE_W  = 24;
  localparam int CURVE_W  = 2;
  localparam int COUNT_W  = 3;
  localparam int SEG_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 43;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CURVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_A        = 3'd3;

  localparam logic [CURVE_W-1:0] CURVE_INHERIT = 2'd0;
  localparam logic [CURVE_W-1:0] CURVE_LINEAR  = 2'd1;
  localparam logic [CURVE_W-1:0] CURVE_STEPPED = 2'd2;
  localparam logic [CURVE_W-1:0] CURVE_SMOOTH  = 2'd3;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_STEPPED = 2'd1,
    MODE_SMOOTH  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_INTERP   = 2'd0,
    STATUS_FALLBACK = 2'd1,
    STATUS_SINGLE   = 2'd2,
    STATUS_PAST     = 2'd3
  } status_t;

  typedef struct packed {
    logic [CURVE_W-1:0]        curve;
    logic signed [VALUE_W-1:0] value;
    logic [TIME_W-1:0]         time_q;
  } point_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        point_count;
    logic [CURVE_W-1:0]        default_curve;
    logic signed [VALUE_W-1:0] fallback_level;
  } cfg_t;

  typedef struct packed {
    status_t                   status;
    logic [SEG_W-1:0]          seg;
    mode_t                     mode;
    logic signed [VALUE_W-1:0] left;
    logic signed [VALUE_W-1:0] right;
  } side_t;

endpackage

/* src/bei_search.sv */
// Segment search stage: clamps the position, picks the segment and its span.
module bei_search #(
  parameter int MAX_POINTS = 5,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bei_pkg::TIME_W-1:0]  position,
  input  bei_pkg::cfg_t               cfg,
  input  bei_pkg::point_t             points [MAX_POINTS],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bei_pkg::TIME_W-1:0]  num,
  output logic [bei_pkg::TIME_W-1:0]  span,
  output bei_pkg::side_t              side_out
);

  localparam int TW = bei_pkg::TIME_W;
  localparam int CW = bei_pkg::COUNT_W;
  localparam logic [31:0] ONE32 = 32'(1) << FRAC_BITS;
  localparam int MIN_SPAN_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int MIN_SPAN_INT = (MIN_SPAN_RAW < 1) ? 1 : MIN_SPAN_RAW;
  localparam logic [TW-1:0] MIN_SPAN = TW'(MIN_SPAN_INT);

  logic [TW-1:0] t;
  logic [CW-1:0] n_sat;
  logic found;
  logic [bei_pkg::SEG_W-1:0] sel_seg;
  logic [TW-1:0] sel_lt;
  logic [TW-1:0] sel_rt;
  logic signed [bei_pkg::VALUE_W-1:0] sel_lv;
  logic signed [bei_pkg::VALUE_W-1:0] sel_rv;
  logic signed [bei_pkg::VALUE_W-1:0] last_v;
  logic [bei_pkg::CURVE_W-1:0] sel_code;
  logic [TW-1:0] span_raw;
  bei_pkg::mode_t mode;
  bei_pkg::side_t side_next;
  logic vld;

  always_comb begin
    t = (32'(position) > ONE32) ? ONE32[TW-1:0] : position;
    n_sat = (cfg.point_count > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cfg.point_count;

    last_v = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (CW'(i + 1) == n_sat) last_v = points[i].value;
    end

    found    = 1'b0;
    sel_seg  = '0;
    sel_lt   = '0;
    sel_rt   = '0;
    sel_lv   = '0;
    sel_rv   = '0;
    sel_code = bei_pkg::CURVE_INHERIT;
    for (int i = 0; i < MAX_POINTS - 1; i++) begin
      if (!found && (CW'(i + 2) <= n_sat) && (t >= points[i].time_q) &&
          (t <= points[i+1].time_q)) begin
        found    = 1'b1;
        sel_seg  = bei_pkg::SEG_W'(i);
        sel_lt   = points[i].time_q;
        sel_rt   = points[i+1].time_q;
        sel_lv   = points[i].value;
        sel_rv   = points[i+1].value;
        sel_code = points[i+1].curve;
      end
    end

    span_raw = sel_rt - sel_lt;

    unique case (sel_code)
      bei_pkg::CURVE_INHERIT: begin
        unique case (cfg.default_curve)
          2'd1:    mode = bei_pkg::MODE_STEPPED;
          2'd2:    mode = bei_pkg::MODE_SMOOTH;
          default: mode = bei_pkg::MODE_LINEAR;
        endcase
      end
      bei_pkg::CURVE_LINEAR:  mode = bei_pkg::MODE_LINEAR;
      bei_pkg::CURVE_STEPPED: mode = bei_pkg::MODE_STEPPED;
      bei_pkg::CURVE_SMOOTH:  mode = bei_pkg::MODE_SMOOTH;
      default:                mode = bei_pkg::MODE_LINEAR;
    endcase

    side_next.mode = mode;
    priority if (n_sat == '0) begin
      side_next.status = bei_pkg::STATUS_FALLBACK;
      side_next.seg    = '0;
      side_next.left   = cfg.fallback_level;
      side_next.right  = cfg.fallback_level;
    end else if (n_sat == CW'(1)) begin
      side_next.status = bei_pkg::STATUS_SINGLE;
      side_next.seg    = '0;
      side_next.left   = points[0].value;
      side_next.right  = points[0].value;
    end else if (found) begin
      side_next.status = bei_pkg::STATUS_INTERP;
      side_next.seg    = sel_seg;
      side_next.left   = sel_lv;
      side_next.right  = sel_rv;
    end else begin
      side_next.status = bei_pkg::STATUS_PAST;
      side_next.seg    = bei_pkg::SEG_W'(n_sat - CW'(1));
      side_next.left   = last_v;
      side_next.right  = last_v;
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      num      <= t - sel_lt;
      span     <= (span_raw < MIN_SPAN) ? MIN_SPAN : span_raw;
      side_out <= side_next;
    end
  end

endmodule

/* src/bei_div.sv */
// Pipelined restoring divider: one quotient bit per stage, local fraction of the span.
module bei_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bei_pkg::TIME_W-1:0]  num,
  input  logic [bei_pkg::TIME_W-1:0]  span,
  input  bei_pkg::side_t              side_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [FRAC_BITS:0]          quotient,
  output bei_pkg::side_t              side_out
);

  localparam int STEPS = FRAC_BITS + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int TW    = bei_pkg::TIME_W;

  logic [STEPS-1:0] vld;
  logic [STEPS:0]   rdy;
  logic [TW-1:0]    rem [STEPS];
  logic [TW-1:0]    dvs [STEPS];
  logic [QW-1:0]    quo [STEPS];
  bei_pkg::side_t   side [STEPS];

  assign rdy[STEPS] = out_ready;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic           prev_vld;
    logic [TW-1:0]  prev_rem;
    logic [TW-1:0]  prev_dvs;
    logic [QW-1:0]  prev_quo;
    bei_pkg::side_t prev_side;
    logic [TW:0]    trial;
    logic [TW:0]    diff;
    logic           take;

    if (k == 0) begin : g_first
      assign prev_vld  = in_valid;
      assign prev_rem  = num;
      assign prev_dvs  = span;
      assign prev_quo  = '0;
      assign prev_side = side_in;
      assign trial     = {1'b0, prev_rem};
    end else begin : g_next
      assign prev_vld  = vld[k-1];
      assign prev_rem  = rem[k-1];
      assign prev_dvs  = dvs[k-1];
      assign prev_quo  = quo[k-1];
      assign prev_side = side[k-1];
      assign trial     = {prev_rem, 1'b0};
    end

    assign take   = trial >= {1'b0, prev_dvs};
    assign diff   = trial - {1'b0, prev_dvs};
    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem[k]  <= take ? diff[TW-1:0] : trial[TW-1:0];
        dvs[k]  <= prev_dvs;
        quo[k]  <= {prev_quo[QW-2:0], take};
        side[k] <= prev_side;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[STEPS-1];
  assign quotient  = quo[STEPS-1];
  assign side_out  = side[STEPS-1];

endmodule

/* src/bei_shape.sv */
// Curve shaping: linear, stepped or smoothstep, over two stages.
module bei_shape #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FRAC_BITS:0]   u_in,
  input  bei_pkg::side_t       side_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS+1:0] frac,
  output bei_pkg::side_t       side_out
);

  localparam int F  = FRAC_BITS;
  localparam int SW = 2 * F + 2;
  localparam int PW = 2 * F + 4;
  localparam logic [F:0]   ONE       = {1'b1, {F{1'b0}}};
  localparam logic [F:0]   HALF      = (F + 1)'(1) << (F - 1);
  localparam logic [F+2:0] THREE_ONE = (F + 3)'(3) << F;

  logic           vld_a;
  logic           vld_b;
  logic           rdy_a;
  logic           rdy_b;
  logic [F:0]     u_c;
  logic [SW-1:0]  sq_full;
  logic [F:0]     u_a;
  logic [F:0]     sq_a;
  bei_pkg::side_t side_a;
  logic [F+2:0]   w;
  logic [PW-1:0]  sm_full;
  logic [F+1:0]   f_next;

  assign u_c     = (u_in > ONE) ? ONE : u_in;
  assign sq_full = SW'(u_c) * SW'(u_c) + SW'(HALF);

  assign w       = THREE_ONE - (F + 3)'({u_a, 1'b0});
  assign sm_full = PW'(sq_a) * PW'(w) + PW'(HALF);

  always_comb begin
    unique case (side_a.mode)
      bei_pkg::MODE_STEPPED: f_next = (u_a < ONE) ? '0 : (F + 2)'(ONE);
      bei_pkg::MODE_SMOOTH:  f_next = sm_full[2*F+1:F];
      default:               f_next = (F + 2)'(u_a);
    endcase
  end

  assign rdy_b     = !vld_b || out_ready;
  assign rdy_a     = !vld_a || rdy_b;
  assign in_ready  = rdy_a;
  assign out_valid = vld_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (rdy_a) vld_a <= in_valid;
      if (rdy_b) vld_b <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      u_a    <= u_c;
      sq_a   <= sq_full[2*F:F];
      side_a <= side_in;
    end
    if (rdy_b) begin
      frac     <= f_next;
      side_out <= side_a;
    end
  end

endmodule

/* src/bei_blend.sv */
// Blend stage: weighted difference, round-half-up rounding, output register.
module bei_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [FRAC_BITS+1:0]               frac,
  input  bei_pkg::side_t                     side_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bei_pkg::VALUE_W-1:0] level,
  output logic [bei_pkg::SEG_W-1:0]          segment,
  output bei_pkg::status_t                   status
);

  localparam int F  = FRAC_BITS;
  localparam int VW = bei_pkg::VALUE_W;
  localparam int MW = VW + F + 4;
  localparam logic [F:0] HALF = (F + 1)'(1) << (F - 1);

  logic                 vld_c;
  logic                 vld_d;
  logic                 rdy_c;
  logic                 rdy_d;
  logic signed [VW:0]   diff;
  logic signed [MW-1:0] diff_ext;
  logic signed [MW-1:0] frac_ext;
  logic signed [MW-1:0] half_ext;
  logic signed [MW-1:0] prod;
  logic signed [MW-1:0] prod_c;
  logic signed [MW-1:0] q;
  bei_pkg::side_t       side_c;

  assign diff     = (VW + 1)'(side_in.right) - (VW + 1)'(side_in.left);
  assign diff_ext = MW'(diff);
  assign frac_ext = $signed(MW'(frac));
  assign half_ext = $signed(MW'(HALF));
  assign prod     = diff_ext * frac_ext + half_ext;
  assign q        = prod_c >>> F;

  assign rdy_d     = !vld_d || out_ready;
  assign rdy_c     = !vld_c || rdy_d;
  assign in_ready  = rdy_c;
  assign out_valid = vld_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else begin
      if (rdy_c) vld_c <= in_valid;
      if (rdy_d) vld_d <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      prod_c <= prod;
      side_c <= side_in;
    end
    if (rdy_d) begin
      level   <= side_c.left + q[VW-1:0];
      segment <= side_c.seg;
      status  <= side_c.status;
    end
  end

endmodule

/* src/breakpoint_envelope_interpolator.sv */
// Top level of the breakpoint envelope interpolator: config registers and pipeline.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------------
//  input   | position                                  | in_valid / in_stall
//  output  | level, segment, status                    | out_valid / out_stall
//  config  | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
// One item per cycle while out_stall is low; the restoring divider resolves one quotient
// bit per stage over FRAC_BITS + 1 stages.
// Reset clears all config registers to zero and empties the pipeline.
// out_stall holds the output item; bubbles inside are squeezed out, and in_stall rises
// only when every stage holds an item. cfg_ready is always high.
module breakpoint_envelope_interpolator #(
  parameter int MAX_POINTS = 5,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bei_pkg::TIME_W-1:0]            position,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bei_pkg::VALUE_W-1:0]    level,
  output logic [bei_pkg::SEG_W-1:0]             segment,
  output logic [1:0]                            status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bei_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bei_pkg::CFG_DATA_W-1:0]        cfg_data
);

  bei_pkg::cfg_t   cfg;
  bei_pkg::point_t points [MAX_POINTS];

  logic                       srch_in_ready;
  logic                       srch_valid;
  logic                       div_in_ready;
  logic [bei_pkg::TIME_W-1:0] srch_num;
  logic [bei_pkg::TIME_W-1:0] srch_span;
  bei_pkg::side_t             srch_side;
  logic                       div_valid;
  logic                       shp_in_ready;
  logic [FRAC_BITS:0]         div_quo;
  bei_pkg::side_t             div_side;
  logic                       shp_valid;
  logic                       bld_in_ready;
  logic [FRAC_BITS+1:0]       shp_frac;
  bei_pkg::side_t             shp_side;
  bei_pkg::status_t           bld_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
      for (int k = 0; k < MAX_POINTS; k++) points[k] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bei_pkg::CFG_POINT_COUNT:    cfg.point_count    <= cfg_data[bei_pkg::COUNT_W-1:0];
        bei_pkg::CFG_DEFAULT_CURVE:  cfg.default_curve  <= cfg_data[bei_pkg::CURVE_W-1:0];
        bei_pkg::CFG_FALLBACK_LEVEL: cfg.fallback_level <= cfg_data[bei_pkg::VALUE_W-1:0];
        default: begin
          for (int k = 0; k < MAX_POINTS; k++) begin
            if (cfg_index == bei_pkg::CFG_IDX_W'(bei_pkg::CFG_POINT_A + k)) begin
              points[k] <= bei_pkg::point_t'(cfg_data);
            end
          end
        end
      endcase
    end
  end

  bei_search #(
    .MAX_POINTS(MAX_POINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (srch_in_ready),
    .position (position),
    .cfg      (cfg),
    .points   (points),
    .out_valid(srch_valid),
    .out_ready(div_in_ready),
    .num      (srch_num),
    .span     (srch_span),
    .side_out (srch_side)
  );

  bei_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (srch_valid),
    .in_ready (div_in_ready),
    .num      (srch_num),
    .span     (srch_span),
    .side_in  (srch_side),
    .out_valid(div_valid),
    .out_ready(shp_in_ready),
    .quotient (div_quo),
    .side_out (div_side)
  );

  bei_shape #(
    .FRAC_BITS(FRAC_BITS)
  ) u_shape (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .in_ready (shp_in_ready),
    .u_in     (div_quo),
    .side_in  (div_side),
    .out_valid(shp_valid),
    .out_ready(bld_in_ready),
    .frac     (shp_frac),
    .side_out (shp_side)
  );

  bei_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .in_valid (shp_valid),
    .in_ready (bld_in_ready),
    .frac     (shp_frac),
    .side_in  (shp_side),
    .out_valid(out_valid),
    .out_ready(!out_stall),
    .level    (level),
    .segment  (segment),
    .status   (bld_status)
  );

  assign in_stall = !srch_in_ready;
  assign status   = bld_status;

  // input backpressure only comes from a held output item
  ast_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output item");

  ast_no_seg_fallback: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (bld_status == bei_pkg::STATUS_FALLBACK ||
                   bld_status == bei_pkg::STATUS_SINGLE)) |-> (segment == '0))
    else $error("nonzero segment on fallback or single point item");

  ast_interp_seg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bld_status == bei_pkg::STATUS_INTERP) |->
      (segment < bei_pkg::SEG_W'(MAX_POINTS - 1)))
    else $error("interpolated segment beyond last segment");

endmodule

/* bench/breakpoint_envelope_interpolator_tb.sv */
// Self-checking testbench for the breakpoint envelope interpolator.
module breakpoint_envelope_interpolator_tb;

  localparam int     MAX_PTS     = 5;
  localparam int     FRAC        = 16;
  localparam longint ONE         = longint'(1) << FRAC;
  localparam longint HALF        = longint'(1) << (FRAC - 1);
  localparam longint MIN_SPAN    = ((ONE + 5000) / 10000 < 1) ? 1 : (ONE + 5000) / 10000;
  localparam int     CYCLE_LIMIT = 300000;
  localparam int     DRAIN_WAIT  = 40;

  typedef struct {
    logic signed [bei_pkg::VALUE_W-1:0] level;
    logic [bei_pkg::SEG_W-1:0]          seg;
    bei_pkg::status_t                   status;
  } env_out_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [bei_pkg::TIME_W-1:0]         position = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [bei_pkg::VALUE_W-1:0] level;
  logic [bei_pkg::SEG_W-1:0]          segment;
  logic [1:0]                         status;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [bei_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [bei_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  // envelope copy used for prediction
  logic [bei_pkg::COUNT_W-1:0]        cur_count;
  logic [bei_pkg::CURVE_W-1:0]        cur_curve;
  logic signed [bei_pkg::VALUE_W-1:0] cur_fallback;
  bei_pkg::point_t                    cur_pts [MAX_PTS];

  // setting to be loaded next
  logic [bei_pkg::COUNT_W-1:0]        set_count;
  logic [bei_pkg::CURVE_W-1:0]        set_curve;
  logic [bei_pkg::VALUE_W-1:0]        set_fallback;
  bei_pkg::point_t                    set_pts [MAX_PTS];

  logic [bei_pkg::TIME_W-1:0] positions_todo [$];
  env_out_t          levels_due [$];
  env_out_t          due;
  logic              took_pos;
  int                accepted_n = 0;
  int                mismatches = 0;
  int                cycle_n = 0;
  int                send_idle = 17;
  int                recv_idle = 68;
  int                hold_left = 0;
  bit                hold_done = 1'b0;

  breakpoint_envelope_interpolator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .level(level), .segment(segment), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bei_pkg::point_t mk_pt(logic [bei_pkg::CURVE_W-1:0] c,
                                            logic [bei_pkg::VALUE_W-1:0] v,
                                            logic [bei_pkg::TIME_W-1:0] tq);
    mk_pt = '{curve: c, value: v, time_q: tq};
  endfunction

  function automatic env_out_t envelope_at(logic [bei_pkg::TIME_W-1:0] pos);
    env_out_t       r;
    int             n;
    longint         t, lt, rt, span, u, f, sq, lv, rv;
    bei_pkg::mode_t m;
    bit             found;
    found = 1'b0;
    r.seg = '0;
    n = int'(cur_count);
    if (n > MAX_PTS) n = MAX_PTS;
    t = longint'(pos);
    if (t > ONE) t = ONE;
    if (n == 0) begin
      r.level = cur_fallback;
      r.status = bei_pkg::STATUS_FALLBACK;
    end else if (n == 1) begin
      r.level = cur_pts[0].value;
      r.status = bei_pkg::STATUS_SINGLE;
    end else begin
      r.level = cur_pts[n-1].value;
      r.seg = bei_pkg::SEG_W'(n - 1);
      r.status = bei_pkg::STATUS_PAST;
      for (int i = 0; i < n - 1; i++) begin
        lt = cur_pts[i].time_q;
        rt = cur_pts[i+1].time_q;
        if (!found && t >= lt && t <= rt) begin
          found = 1'b1;
          span = rt - lt;
          if (span < MIN_SPAN) span = MIN_SPAN;
          u = ((t - lt) << FRAC) / span;
          if (u > ONE) u = ONE;
          case (cur_pts[i+1].curve)
            bei_pkg::CURVE_LINEAR:  m = bei_pkg::MODE_LINEAR;
            bei_pkg::CURVE_STEPPED: m = bei_pkg::MODE_STEPPED;
            bei_pkg::CURVE_SMOOTH:  m = bei_pkg::MODE_SMOOTH;
            default: begin
              case (cur_curve)
                bei_pkg::MODE_STEPPED: m = bei_pkg::MODE_STEPPED;
                bei_pkg::MODE_SMOOTH:  m = bei_pkg::MODE_SMOOTH;
                default:               m = bei_pkg::MODE_LINEAR;
              endcase
            end
          endcase
          case (m)
            bei_pkg::MODE_STEPPED: f = (u < ONE) ? 0 : ONE;
            bei_pkg::MODE_SMOOTH: begin
              sq = (u * u + HALF) >>> FRAC;
              f = (sq * (3 * ONE - 2 * u) + HALF) >>> FRAC;
            end
            default: f = u;
          endcase
          lv = $signed(cur_pts[i].value);
          rv = $signed(cur_pts[i+1].value);
          // round half up: add half, then floor division via arithmetic shift
          r.level = bei_pkg::VALUE_W'(lv + (((rv - lv) * f + HALF) >>> FRAC));
          r.seg = bei_pkg::SEG_W'(i);
          r.status = bei_pkg::STATUS_INTERP;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  // monitor: config copy, expectations, result check
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst) begin
      took_pos = 1'b0;
      cur_count = '0;
      cur_curve = '0;
      cur_fallback = '0;
      foreach (cur_pts[i]) cur_pts[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bei_pkg::CFG_POINT_COUNT:    cur_count = cfg_data[bei_pkg::COUNT_W-1:0];
          bei_pkg::CFG_DEFAULT_CURVE:  cur_curve = cfg_data[bei_pkg::CURVE_W-1:0];
          bei_pkg::CFG_FALLBACK_LEVEL: cur_fallback = cfg_data[bei_pkg::VALUE_W-1:0];
          default: cur_pts[cfg_index - bei_pkg::CFG_POINT_A] = cfg_data;
        endcase
      end
      took_pos = in_valid && !in_stall;
      if (took_pos) begin
        levels_due.push_back(envelope_at(position));
        accepted_n++;
      end
      if (out_valid && !out_stall) begin
        if (levels_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected item: level %0d segment %0d status %0d",
                                  level, segment, status));
        end else begin
          due = levels_due.pop_front();
          if (level !== due.level || segment !== due.seg || status !== due.status)
            flag_mismatch($sformatf(
              "mismatch: level exp %0d got %0d, segment exp %0d got %0d, status exp %0d got %0d",
              due.level, level, due.seg, segment, due.status, status));
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || took_pos)) begin
      if (positions_todo.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_valid <= 1'b1;
        position <= positions_todo.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with one long hold-off to back the pipeline up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_n >= 200 && positions_todo.size() >= 30) begin
      hold_done = 1'b1;
      hold_left = 160;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  task automatic put_reg(logic [bei_pkg::CFG_IDX_W-1:0] idx,
                         logic [bei_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs();
    put_reg(bei_pkg::CFG_POINT_COUNT, bei_pkg::CFG_DATA_W'(set_count));
    put_reg(bei_pkg::CFG_DEFAULT_CURVE, bei_pkg::CFG_DATA_W'(set_curve));
    put_reg(bei_pkg::CFG_FALLBACK_LEVEL, bei_pkg::CFG_DATA_W'(set_fallback));
    for (int i = 0; i < MAX_PTS; i++)
      put_reg(bei_pkg::CFG_POINT_A + bei_pkg::CFG_IDX_W'(i), set_pts[i]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (positions_todo.size() != 0 || in_valid || levels_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int batch, done_rand, tcur, pick, p;
    bit sorted;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: no points, zero fallback
    positions_todo.push_back(17'd0);
    positions_todo.push_back(17'd131071);
    drain();

    // no points, most negative fallback
    set_count = 3'd0;
    set_curve = bei_pkg::MODE_LINEAR;
    set_fallback = 24'h800000;
    foreach (set_pts[i]) set_pts[i] = '0;
    program_regs();
    positions_todo.push_back(17'd0);
    positions_todo.push_back(17'd65536);
    positions_todo.push_back(17'd131071);
    drain();

    // single point
    set_count = 3'd1;
    set_fallback = 24'h7FFFFF;
    set_pts[0] = mk_pt(bei_pkg::CURVE_SMOOTH, 24'h7FFFFF, 17'd40000);
    program_regs();
    positions_todo.push_back(17'd0);
    positions_todo.push_back(17'd70000);
    drain();

    // full envelope, every curve, tiny span, past last point
    set_count = 3'd5;
    set_curve = bei_pkg::MODE_SMOOTH;
    set_pts[0] = mk_pt(bei_pkg::CURVE_LINEAR, 24'd0, 17'd0);
    set_pts[1] = mk_pt(bei_pkg::CURVE_LINEAR, 24'h800000, 17'd16384);
    set_pts[2] = mk_pt(bei_pkg::CURVE_STEPPED, 24'h7FFFFF, 17'd32768);
    set_pts[3] = mk_pt(bei_pkg::CURVE_SMOOTH, -24'sd1000000, 17'd32771);
    set_pts[4] = mk_pt(bei_pkg::CURVE_INHERIT, 24'd5000000, 17'd58982);
    program_regs();
    positions_todo.push_back(17'd0);
    positions_todo.push_back(17'd8192);
    positions_todo.push_back(17'd16384);
    positions_todo.push_back(17'd24000);
    positions_todo.push_back(17'd32767);
    positions_todo.push_back(17'd32768);
    positions_todo.push_back(17'd32770);
    positions_todo.push_back(17'd45000);
    positions_todo.push_back(17'd58982);
    positions_todo.push_back(17'd65536);
    positions_todo.push_back(17'd131071);
    drain();

    // count above the maximum, default curve 3, unordered and zero-span points
    set_count = 3'd7;
    set_curve = 2'd3;
    set_pts[0] = mk_pt(bei_pkg::CURVE_INHERIT, 24'd100, 17'd30000);
    set_pts[1] = mk_pt(bei_pkg::CURVE_INHERIT, -24'sd200, 17'd10000);
    set_pts[2] = mk_pt(bei_pkg::CURVE_STEPPED, 24'd7, 17'd50000);
    set_pts[3] = mk_pt(bei_pkg::CURVE_INHERIT, 24'd9, 17'd50000);
    set_pts[4] = mk_pt(bei_pkg::CURVE_LINEAR, 24'h123456, 17'd131071);
    program_regs();
    positions_todo.push_back(17'd20000);
    positions_todo.push_back(17'd5000);
    positions_todo.push_back(17'd50000);
    positions_todo.push_back(17'd65536);
    positions_todo.push_back(17'd40000);
    drain();

    done_rand = 0;
    while (done_rand < 1150) begin
      if (done_rand < 383) begin
        send_idle = 17;
        recv_idle = 68;
      end else if (done_rand < 766) begin
        send_idle = 68;
        recv_idle = 17;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      pick = $urandom_range(0, 9);
      set_count = (pick < 1) ? 3'd0 : (pick < 2) ? 3'd1 :
                  (pick < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(2, 5));
      set_curve = 2'($urandom_range(0, 3));
      set_fallback = 24'($urandom);
      sorted = ($urandom_range(0, 3) != 0);
      tcur = $urandom_range(0, 6000);
      for (int i = 0; i < MAX_PTS; i++) begin
        set_pts[i].time_q = sorted ? 17'(tcur) : 17'($urandom_range(0, 131071));
        if ($urandom_range(0, 7) == 0)
          set_pts[i].value = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        else
          set_pts[i].value = 24'($urandom);
        set_pts[i].curve = 2'($urandom_range(0, 3));
        tcur += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(2000, 24000);
        if (tcur > 131071) tcur = 131071;
      end
      program_regs();
      batch = $urandom_range(40, 80);
      repeat (batch) begin
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
          // on or next to a breakpoint
          p = int'(set_pts[$urandom_range(0, MAX_PTS - 1)].time_q) + $urandom_range(0, 2) - 1;
          if (p < 0) p = 0;
          if (p > 131071) p = 131071;
        end else if (pick == 2) begin
          p = $urandom_range(0, 131071);
        end else begin
          p = $urandom_range(0, 65536);
        end
        positions_todo.push_back(17'(p));
      end
      done_rand += batch;
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
